### design/pcbs_pkg.sv
// shared types and constants of the per-class box suppression core
package pcbs_pkg;

    localparam int unsigned RESULT_LIMIT = 64;
    localparam int unsigned NRES_W       = $clog2(RESULT_LIMIT + 1);
    localparam int unsigned SCORE_W      = 8;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 1'b1;

    localparam logic [SCORE_W-1:0] SCORE_THR_RESET   = 8'd128;
    localparam logic [SCORE_W-1:0] OVERLAP_THR_RESET = 8'd115;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FIND,
        ST_PICK,
        ST_TAKE,
        ST_SUPP,
        ST_WAIT_OUT,
        ST_DONE
    } t_state;

    typedef enum logic {
        RD_FIND,
        RD_SUPP
    } t_rd_mode;

    typedef enum logic [1:0] {
        OSEL_PEND,
        OSEL_BEST,
        OSEL_MARK
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        t_rd_mode rd_mode;
        logic     best_clear;
        logic     take;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
        logic     frame_clear;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic busy;
    } t_sts;

endpackage

### design/per_class_box_suppression_core.sv
// top level of the per-class box suppression core
//
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    has_box, box corners, score, class, frame_end
// out       output     o_out_valid / i_out_ready  kept box, score, class, none_kept, last_result
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// loading takes one request per cycle; the block then scans the single-port box memory
// per kept box: one ranking pass and one overlap pass over the N boxes stored,
// and each result waits in the output register until i_out_ready takes it.
// no input is taken from frame end until the last result has been taken.
// reset is synchronous and active low; box and score memories need no clearing.
module per_class_box_suppression_core
    import pcbs_pkg::*;
#(
    parameter int unsigned MAX_BOXES  = 64,
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned CLASS_BITS = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_has_box,
    input  logic signed [COORD_BITS-1:0] i_x_min,
    input  logic signed [COORD_BITS-1:0] i_y_min,
    input  logic signed [COORD_BITS-1:0] i_x_max,
    input  logic signed [COORD_BITS-1:0] i_y_max,
    input  logic [SCORE_W-1:0]           i_score,
    input  logic [CLASS_BITS-1:0]        i_class_index,
    input  logic                         i_frame_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_kept_x_min,
    output logic signed [COORD_BITS-1:0] o_kept_y_min,
    output logic signed [COORD_BITS-1:0] o_kept_x_max,
    output logic signed [COORD_BITS-1:0] o_kept_y_max,
    output logic [SCORE_W-1:0]           o_kept_score,
    output logic [CLASS_BITS-1:0]        o_kept_class,
    output logic                         o_none_kept,
    output logic                         o_last_result
);

    localparam int unsigned AW = $clog2(MAX_BOXES);
    localparam int unsigned CW = $clog2(MAX_BOXES + 1);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [CW-1:0] w_count;
    logic [AW-1:0] w_rd_addr;

    pcbs_ctrl #(
        .MAX_BOXES(MAX_BOXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_frame_end),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .i_count     (w_count),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    pcbs_datapath #(
        .MAX_BOXES (MAX_BOXES),
        .COORD_BITS(COORD_BITS),
        .CLASS_BITS(CLASS_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_has_box     (i_has_box),
        .i_x_min       (i_x_min),
        .i_y_min       (i_y_min),
        .i_x_max       (i_x_max),
        .i_y_max       (i_y_max),
        .i_score       (i_score),
        .i_class_index (i_class_index),
        .i_cmd         (w_cmd),
        .i_rd_addr     (w_rd_addr),
        .o_sts         (w_sts),
        .o_count       (w_count),
        .o_kept_x_min  (o_kept_x_min),
        .o_kept_y_min  (o_kept_y_min),
        .o_kept_x_max  (o_kept_x_max),
        .o_kept_y_max  (o_kept_y_max),
        .o_kept_score  (o_kept_score),
        .o_kept_class  (o_kept_class),
        .o_none_kept   (o_none_kept),
        .o_last_result (o_last_result)
    );

`ifndef SYNTHESIS
    // loading and result hand-off never overlap
    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");

    // an empty-frame marker is always the last result
    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_none_kept) |-> o_last_result)
        else $error("marker without last_result");

    // store fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(MAX_BOXES))
        else $error("box count beyond store depth");

    // a load request never coincides with a memory scan
    a_load_idle_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_cmd.rd_en && !w_sts.busy)
        else $error("load during scan");
`endif

endmodule

### design/pcbs_datapath.sv
// box store, ranking scan, overlap pipeline and result register
module pcbs_datapath
    import pcbs_pkg::*;
#(
    parameter int unsigned MAX_BOXES  = 64,
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned CLASS_BITS = 7,
    localparam int unsigned AW = $clog2(MAX_BOXES),
    localparam int unsigned CW = $clog2(MAX_BOXES + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_has_box,
    input  logic signed [COORD_BITS-1:0] i_x_min,
    input  logic signed [COORD_BITS-1:0] i_y_min,
    input  logic signed [COORD_BITS-1:0] i_x_max,
    input  logic signed [COORD_BITS-1:0] i_y_max,
    input  logic [SCORE_W-1:0]           i_score,
    input  logic [CLASS_BITS-1:0]        i_class_index,
    input  t_cmd                         i_cmd,
    input  logic [AW-1:0]                i_rd_addr,
    output t_sts                         o_sts,
    output logic [CW-1:0]                o_count,
    output logic signed [COORD_BITS-1:0] o_kept_x_min,
    output logic signed [COORD_BITS-1:0] o_kept_y_min,
    output logic signed [COORD_BITS-1:0] o_kept_x_max,
    output logic signed [COORD_BITS-1:0] o_kept_y_max,
    output logic [SCORE_W-1:0]           o_kept_score,
    output logic [CLASS_BITS-1:0]        o_kept_class,
    output logic                         o_none_kept,
    output logic                         o_last_result
);

    localparam int unsigned CB   = COORD_BITS;
    localparam int unsigned EW   = 4 * CB + SCORE_W + CLASS_BITS;
    localparam int unsigned DW   = CB + 1;
    localparam int unsigned PW   = 2 * DW;
    localparam int unsigned UW   = PW + 1;
    localparam int unsigned CMPW = UW + 9;

    logic [SCORE_W-1:0]   r_score_thr;
    logic [SCORE_W-1:0]   r_ovl_thr;
    logic [CW-1:0]        r_count;
    logic [EW-1:0]        r_mem [MAX_BOXES];
    logic                 r_flag [MAX_BOXES];
    logic [EW-1:0]        r_rd_data;
    logic                 r_rd_flag;

    logic                 w_mem_we;
    logic [EW-1:0]        w_entry;
    logic                 w_fl_we;
    logic [AW-1:0]        w_fl_addr;
    logic                 w_fl_din;

    // find stage
    logic                 r_v0;
    t_rd_mode             r_mode0;
    logic [AW-1:0]        r_idx0;
    logic                 r_found;
    logic [EW-1:0]        r_best;
    logic [AW-1:0]        r_best_idx;
    logic [EW-1:0]        r_pend;
    logic [AW-1:0]        r_pend_idx;

    // overlap pipeline
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic                 r_c1, r_c2, r_c3, r_c4;
    logic [AW-1:0]        r_idx1, r_idx2, r_idx3, r_idx4;
    logic signed [DW-1:0] r_iw1, r_ih1, r_wa1, r_ha1, r_wb1, r_hb1;
    logic signed [PW-1:0] r_inter2, r_aa2, r_ab2;
    logic signed [CMPW-1:0] r_lhs3, r_lhs4, r_rhs4;
    logic signed [UW-1:0] r_uni3;
    logic                 w_hit;

    // result register
    logic [EW-1:0]        r_o_entry;
    logic                 r_o_none;
    logic                 r_o_last;

    // entry fields
    logic signed [CB-1:0] c_x0, c_y0, c_x1, c_y1, b_x0, p_x0, p_y0, p_x1, p_y1;
    logic [SCORE_W-1:0]   c_sc, b_sc;
    logic [CLASS_BITS-1:0] c_cls, b_cls, p_cls;
    logic                 w_before, w_upd;
    logic signed [CB-1:0] w_ix0, w_iy0, w_ix1, w_iy1;
    logic signed [DW-1:0] w_iw, w_ih;
    logic                 w_cand;

    assign w_entry = {i_class_index, i_score, i_y_max, i_x_max, i_y_min, i_x_min};
    assign w_mem_we = i_cmd.load && i_has_box && (i_score > r_score_thr)
                      && (r_count < CW'(MAX_BOXES));

    assign c_x0  = $signed(r_rd_data[CB-1:0]);
    assign c_y0  = $signed(r_rd_data[2*CB-1:CB]);
    assign c_x1  = $signed(r_rd_data[3*CB-1:2*CB]);
    assign c_y1  = $signed(r_rd_data[4*CB-1:3*CB]);
    assign c_sc  = r_rd_data[4*CB+SCORE_W-1:4*CB];
    assign c_cls = r_rd_data[EW-1:4*CB+SCORE_W];
    assign b_x0  = $signed(r_best[CB-1:0]);
    assign b_sc  = r_best[4*CB+SCORE_W-1:4*CB];
    assign b_cls = r_best[EW-1:4*CB+SCORE_W];
    assign p_x0  = $signed(r_pend[CB-1:0]);
    assign p_y0  = $signed(r_pend[2*CB-1:CB]);
    assign p_x1  = $signed(r_pend[3*CB-1:2*CB]);
    assign p_y1  = $signed(r_pend[4*CB-1:3*CB]);
    assign p_cls = r_pend[EW-1:4*CB+SCORE_W];

    // later index never wins a full tie
    assign w_before = (c_cls < b_cls)
                   || ((c_cls == b_cls) && (c_sc > b_sc))
                   || ((c_cls == b_cls) && (c_sc == b_sc) && (c_x0 < b_x0));
    assign w_upd = r_v0 && (r_mode0 == RD_FIND) && !r_rd_flag && (!r_found || w_before);

    assign w_ix0 = (c_x0 > p_x0) ? c_x0 : p_x0;
    assign w_iy0 = (c_y0 > p_y0) ? c_y0 : p_y0;
    assign w_ix1 = (c_x1 < p_x1) ? c_x1 : p_x1;
    assign w_iy1 = (c_y1 < p_y1) ? c_y1 : p_y1;
    assign w_iw  = DW'(w_ix1) - DW'(w_ix0);
    assign w_ih  = DW'(w_iy1) - DW'(w_iy0);
    assign w_cand = r_v0 && (r_mode0 == RD_SUPP) && !r_rd_flag && (c_cls == p_cls)
                    && (r_idx0 != r_pend_idx) && (w_iw > 0) && (w_ih > 0);

    assign w_hit = r_v4 && r_c4 && (r_lhs4 > r_rhs4);

    always_comb begin
        w_fl_we   = 1'b0;
        w_fl_addr = r_count[AW-1:0];
        w_fl_din  = 1'b0;
        if (w_mem_we) begin
            w_fl_we = 1'b1;
        end else if (i_cmd.take) begin
            w_fl_we   = 1'b1;
            w_fl_addr = r_best_idx;
            w_fl_din  = 1'b1;
        end else if (w_hit) begin
            w_fl_we   = 1'b1;
            w_fl_addr = r_idx4;
            w_fl_din  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[AW-1:0]] <= w_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fl_we) begin
            r_flag[w_fl_addr] <= w_fl_din;
        end
        if (i_cmd.rd_en) begin
            r_rd_flag <= r_flag[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr <= SCORE_THR_RESET;
            r_ovl_thr   <= OVERLAP_THR_RESET;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCORE_THR:   r_score_thr <= i_cfg_data;
                    CFG_OVERLAP_THR: r_ovl_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.frame_clear) begin
                r_count <= '0;
            end else if (w_mem_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.best_clear) begin
                r_found <= 1'b0;
            end else if (w_upd) begin
                r_found <= 1'b1;
            end
            r_v0 <= i_cmd.rd_en;
            r_v1 <= r_v0 && (r_mode0 == RD_SUPP);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode0 <= i_cmd.rd_mode;
        r_idx0  <= i_rd_addr;
        if (w_upd) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_idx0;
        end
        if (i_cmd.take) begin
            r_pend     <= r_best;
            r_pend_idx <= r_best_idx;
        end
        // stage 1: intersection and box extents
        r_idx1 <= r_idx0;
        r_c1   <= w_cand;
        r_iw1  <= w_iw;
        r_ih1  <= w_ih;
        r_wa1  <= DW'(p_x1) - DW'(p_x0);
        r_ha1  <= DW'(p_y1) - DW'(p_y0);
        r_wb1  <= DW'(c_x1) - DW'(c_x0);
        r_hb1  <= DW'(c_y1) - DW'(c_y0);
        // stage 2: areas
        r_idx2   <= r_idx1;
        r_c2     <= r_c1;
        r_inter2 <= r_iw1 * r_ih1;
        r_aa2    <= r_wa1 * r_ha1;
        r_ab2    <= r_wb1 * r_hb1;
        // stage 3: union and scaled intersection
        r_idx3 <= r_idx2;
        r_c3   <= r_c2;
        r_uni3 <= UW'(r_aa2) + UW'(r_ab2) - UW'(r_inter2);
        r_lhs3 <= {{(CMPW - PW - 8){r_inter2[PW-1]}}, r_inter2, 8'd0};
        // stage 4: threshold times union
        r_idx4 <= r_idx3;
        r_c4   <= r_c3;
        r_lhs4 <= r_lhs3;
        r_rhs4 <= $signed({1'b0, r_ovl_thr}) * r_uni3;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_last <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OSEL_PEND: begin
                    r_o_entry <= r_pend;
                    r_o_none  <= 1'b0;
                end
                OSEL_BEST: begin
                    r_o_entry <= r_best;
                    r_o_none  <= 1'b0;
                end
                default: begin
                    r_o_entry <= '0;
                    r_o_none  <= 1'b1;
                end
            endcase
        end
    end

    assign o_sts.found = r_found;
    assign o_sts.busy  = r_v0 | r_v1 | r_v2 | r_v3 | r_v4;
    assign o_count     = r_count;

    assign o_kept_x_min  = $signed(r_o_entry[CB-1:0]);
    assign o_kept_y_min  = $signed(r_o_entry[2*CB-1:CB]);
    assign o_kept_x_max  = $signed(r_o_entry[3*CB-1:2*CB]);
    assign o_kept_y_max  = $signed(r_o_entry[4*CB-1:3*CB]);
    assign o_kept_score  = r_o_entry[4*CB+SCORE_W-1:4*CB];
    assign o_kept_class  = r_o_entry[EW-1:4*CB+SCORE_W];
    assign o_none_kept   = r_o_none;
    assign o_last_result = r_o_last;

endmodule

### design/pcbs_ctrl.sv
// sequencer for loading, ranking scans, suppression passes and result hand-off
module pcbs_ctrl
    import pcbs_pkg::*;
#(
    parameter int unsigned MAX_BOXES = 64,
    localparam int unsigned AW = $clog2(MAX_BOXES),
    localparam int unsigned CW = $clog2(MAX_BOXES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_frame_end,
    input  logic          i_out_ready,
    input  t_sts          i_sts,
    input  logic [CW-1:0] i_count,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_rd_addr
);

    t_state            r_state, n_state;
    t_state            r_after, n_after;
    logic [CW-1:0]     r_ctr, n_ctr;
    logic [NRES_W-1:0] r_nres, n_nres;
    logic              r_have_pend, n_have_pend;
    logic              w_scan_end;
    logic              w_at_limit;

    assign w_scan_end = (r_ctr == i_count) && !i_sts.busy;
    assign w_at_limit = (r_nres + NRES_W'(1)) == NRES_W'(RESULT_LIMIT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:     if (i_in_valid && i_frame_end) n_state = ST_FIND;
            ST_FIND:     if (w_scan_end) n_state = ST_PICK;
            ST_PICK: begin
                if (i_sts.found && !r_have_pend) n_state = ST_TAKE;
                else n_state = ST_WAIT_OUT;
            end
            ST_TAKE:     n_state = w_at_limit ? ST_WAIT_OUT : ST_SUPP;
            ST_SUPP:     if (w_scan_end) n_state = ST_FIND;
            ST_WAIT_OUT: if (i_out_ready) n_state = r_after;
            ST_DONE:     n_state = ST_LOAD;
            default:     n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.out_sel = OSEL_MARK;
        o_in_ready   = (r_state == ST_LOAD);
        o_out_valid  = (r_state == ST_WAIT_OUT);
        n_after      = r_after;
        n_nres       = r_nres;
        n_have_pend  = r_have_pend;
        n_ctr        = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load       = i_in_valid;
                o_cmd.best_clear = 1'b1;
            end
            ST_FIND, ST_SUPP: begin
                o_cmd.rd_mode = (r_state == ST_FIND) ? RD_FIND : RD_SUPP;
                o_cmd.rd_en   = (r_ctr < i_count);
                n_ctr = o_cmd.rd_en ? r_ctr + CW'(1) : r_ctr;
                if (r_state == ST_SUPP && w_scan_end) begin
                    o_cmd.best_clear = 1'b1;
                    n_ctr = '0;
                end
            end
            ST_PICK: begin
                o_cmd.out_load = !(i_sts.found && !r_have_pend);
                o_cmd.out_sel  = r_have_pend ? OSEL_PEND : OSEL_MARK;
                o_cmd.out_last = !i_sts.found;
                n_after = i_sts.found ? ST_TAKE : ST_DONE;
            end
            ST_TAKE: begin
                o_cmd.take  = 1'b1;
                n_nres      = r_nres + NRES_W'(1);
                n_have_pend = 1'b1;
                // result cap reached: hand over the winner as the final one
                if (w_at_limit) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_BEST;
                    o_cmd.out_last = 1'b1;
                    n_after        = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.frame_clear = 1'b1;
                n_nres      = '0;
                n_have_pend = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_rd_addr = r_ctr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_after     <= ST_DONE;
            r_ctr       <= '0;
            r_nres      <= '0;
            r_have_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_ctr       <= n_ctr;
            r_nres      <= n_nres;
            r_have_pend <= n_have_pend;
        end
    end

endmodule
